// ----- rtl/core/dkms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkms_pkg
// Shared types and field widths of the duplex key matrix scanner.
// ----------------------------------------------------------------------------
package dkms_pkg;

    localparam int COLUMN_W  = 16;  // sampled column lines
    localparam int ROW_W     = 8;   // sampled row lines
    localparam int LINE_W    = 4;   // drive line index
    localparam int ROW_IDX_W = 3;   // reported row index
    localparam int KEYS_W    = 16;  // reported key bits per row
    localparam int PH_EXT_W  = 6;   // room for any phase count up to 32

    // One classified sample word, front to back
    typedef struct packed {
        logic                is_col;      // phase drives an odd column
        logic [LINE_W-1:0]   idx;         // row, or column pair k
        logic                last_phase;  // word closes the scan
        logic                next_is_col;
        logic [LINE_W-1:0]   next_line;
        logic [COLUMN_W-1:0] cols;
        logic [ROW_W-1:0]    rows;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/dkms_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkms_front
// Takes sample words, tracks the scan phase and tags each word with what
// the phase means and which line is driven next.
// ----------------------------------------------------------------------------
module dkms_front #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [dkms_pkg::COLUMN_W-1:0]       column_levels,
    input  wire  [dkms_pkg::ROW_W-1:0]          row_levels,
    output logic                                cmd_valid,
    input  wire                                 cmd_ready,
    output dkms_pkg::cmd_t                      cmd
);

    localparam int PHASES = ROWS + COLS / 2;
    localparam int PH_W   = $clog2(PHASES);
    localparam int EW     = dkms_pkg::PH_EXT_W;
    localparam logic [EW-1:0] ROWS_E = EW'(ROWS);

    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic [EW-1:0]   ph_e;
    logic [EW-1:0]   colk;
    logic [EW-1:0]   np_e;
    logic [EW-1:0]   ncolk;
    logic            last_phase;
    logic            next_is_col;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        ph_e        = EW'(phase_reg);
        colk        = ph_e - ROWS_E;
        last_phase  = (phase_reg == PH_W'(PHASES - 1));
        phase_next  = last_phase ? '0 : phase_reg + PH_W'(1);
        np_e        = EW'(phase_next);
        ncolk       = np_e - ROWS_E;
        next_is_col = (np_e >= ROWS_E);

        cmd.is_col      = (ph_e >= ROWS_E);
        cmd.idx         = cmd.is_col ? colk[dkms_pkg::LINE_W-1:0]
                                     : ph_e[dkms_pkg::LINE_W-1:0];
        cmd.last_phase  = last_phase;
        cmd.next_is_col = next_is_col;
        // odd column 2k+1, kept to the field width
        cmd.next_line   = next_is_col ? {ncolk[dkms_pkg::LINE_W-2:0], 1'b1}
                                      : np_e[dkms_pkg::LINE_W-1:0];
        cmd.cols        = column_levels;
        cmd.rows        = row_levels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (in_valid && cmd_ready)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dkms_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkms_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module dkms_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  dkms_pkg::cmd_t      in_cmd,
    output logic                out_valid,
    input  wire                 out_ready,
    output dkms_pkg::cmd_t      out_cmd
);

    dkms_pkg::cmd_t q_mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dkms_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkms_back
// Holds the key matrix, applies each word to it and drives the result
// register: a row dump for a scan's last word, else a progress word.
// ----------------------------------------------------------------------------
module dkms_back #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cmd_valid,
    output logic                                cmd_ready,
    input  dkms_pkg::cmd_t                      cmd,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                drive_is_column,
    output logic [dkms_pkg::LINE_W-1:0]         drive_line,
    output logic [dkms_pkg::ROW_IDX_W-1:0]      row_index,
    output logic [dkms_pkg::KEYS_W-1:0]         row_keys,
    output logic                                scan_done,
    output logic                                changed,
    output logic                                last
);

    localparam int RI_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW   = dkms_pkg::LINE_W;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic [COLS-1:0] key_reg [ROWS];
    wire  [COLS-1:0] key_next [ROWS];
    wire  [ROWS-1:0] row_chg;

    logic            state_reg;
    logic [RI_W-1:0] dump_cnt_reg;
    logic            seen_reg;
    logic            seen_next;
    logic            out_valid_reg;
    logic            out_free;
    logic            pop;
    logic            dump_load;
    logic            last_row;

    // per-key update: even bits from the driven row, odd bits from the
    // driven column; lines outside the sampled width read low
    genvar r, c;
    generate
        for (r = 0; r < ROWS; r++)
        begin : g_row
            for (c = 0; c < COLS; c++)
            begin : g_col
                wire smp;
                wire hit;
                if (c % 2 == 0)
                begin : g_even
                    if (c < dkms_pkg::COLUMN_W)
                    begin : g_in
                        assign smp = cmd.cols[c];
                    end
                    else
                    begin : g_out
                        assign smp = 1'b0;
                    end
                    assign hit = !cmd.is_col && (cmd.idx == LW'(r));
                end
                else
                begin : g_odd
                    if (r < dkms_pkg::ROW_W)
                    begin : g_in
                        assign smp = cmd.rows[r];
                    end
                    else
                    begin : g_out
                        assign smp = 1'b0;
                    end
                    assign hit = cmd.is_col && (cmd.idx == LW'(c / 2));
                end
                assign key_next[r][c] = hit ? ~smp : key_reg[r][c];
            end
            assign row_chg[r] = |(key_next[r] ^ key_reg[r]);
        end
    endgenerate

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_RUN) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign dump_load = (state_reg == ST_DUMP) && out_free;
    assign last_row  = (dump_cnt_reg == RI_W'(ROWS - 1));
    assign seen_next = seen_reg | (|row_chg);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            dump_cnt_reg  <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_RUN:
                begin
                    if (pop)
                    begin
                        seen_reg <= seen_next;
                        if (cmd.last_phase)
                        begin
                            state_reg    <= ST_DUMP;
                            dump_cnt_reg <= '0;
                        end
                    end
                end
                ST_DUMP:
                begin
                    if (dump_load)
                    begin
                        if (last_row)
                        begin
                            state_reg <= ST_RUN;
                            seen_reg  <= 1'b0;
                        end
                        else
                        begin
                            dump_cnt_reg <= dump_cnt_reg + RI_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase

            if ((pop && !cmd.last_phase) || dump_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop && !cmd.last_phase)
        begin
            drive_is_column <= cmd.next_is_col;
            drive_line      <= cmd.next_line;
            row_index       <= '0;
            row_keys        <= '0;
            scan_done       <= 1'b0;
            changed         <= 1'b0;
            last            <= 1'b1;
        end
        else if (dump_load)
        begin
            // next scan starts on row 0
            drive_is_column <= 1'b0;
            drive_line      <= '0;
            row_index       <= dkms_pkg::ROW_IDX_W'(LW'(dump_cnt_reg));
            row_keys        <= dkms_pkg::KEYS_W'(key_reg[dump_cnt_reg]);
            scan_done       <= 1'b1;
            changed         <= seen_reg;
            last            <= last_row;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/duplex_key_matrix_scanner_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// duplex_key_matrix_scanner_core
// Duplex key matrix scanner: rows then odd columns driven in turn.
// ----------------------------------------------------------------------------
// Each input word is one settled sample of all lines for the current phase;
// a scan has ROWS + COLS/2 phases. Every word except the one closing a scan
// gives one result naming the next line to drive, registered when the back
// end takes the word. The closing word gives ROWS results, rows 0 upwards,
// one per cycle while the receiver is ready, from the single result
// register; the back end takes no new word while the row dump runs. A
// two-word queue lets up to two samples come in while the dump runs.
module duplex_key_matrix_scanner_core #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [dkms_pkg::COLUMN_W-1:0]       column_levels,
    input  wire  [dkms_pkg::ROW_W-1:0]          row_levels,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                drive_is_column,
    output logic [dkms_pkg::LINE_W-1:0]         drive_line,
    output logic [dkms_pkg::ROW_IDX_W-1:0]      row_index,
    output logic [dkms_pkg::KEYS_W-1:0]         row_keys,
    output logic                                scan_done,
    output logic                                changed,
    output logic                                last
);

    logic           f_valid;
    logic           f_ready;
    dkms_pkg::cmd_t f_cmd;
    logic           b_valid;
    logic           b_ready;
    dkms_pkg::cmd_t b_cmd;

    dkms_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_levels (column_levels),
        .row_levels    (row_levels),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    dkms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    dkms_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (b_valid),
        .cmd_ready       (b_ready),
        .cmd             (b_cmd),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive_is_column (drive_is_column),
        .drive_line      (drive_line),
        .row_index       (row_index),
        .row_keys        (row_keys),
        .scan_done       (scan_done),
        .changed         (changed),
        .last            (last)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duplex key matrix scanner core.
// ----------------------------------------------------------------------------
// Sample words go through full scans: rows first, then odd columns. A
// directed table comes first: lines at their extremes, and progress results
// typed in where they are plain. Random scans follow, made of fresh noise,
// of repeats of the previous scan (changed flag low) and of repeats with one
// key flipped. A scan model in the bench predicts every progress and row-dump
// result, and the results are compared field by field in arrival order. Both
// sides stall at random. There is one long receiver hold-off and one sender
// pause until the block has drained, and a closing stretch with no stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS         = 8;
    localparam int COLS         = 16;
    localparam int PHASES       = ROWS + COLS / 2;
    localparam int RANDOM_WORDS = 196;
    localparam int HOLD_AT      = 50;
    localparam int DRAIN_AT     = 110;
    localparam int QUIET_AT     = 156;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 2 * ROWS + COLS / 2 + 8;
    localparam int CYCLE_LIMIT  = 60000;

    typedef enum int {SCAN_NOISE, SCAN_REPEAT, SCAN_FLIP} scan_mode_t;

    typedef struct {
        logic                           is_col;
        logic [dkms_pkg::LINE_W-1:0]    line;
        logic [dkms_pkg::ROW_IDX_W-1:0] row;
        logic [dkms_pkg::KEYS_W-1:0]    keys;
        logic                           done;
        logic                           chg;
        logic                           fin;
    } scan_report_t;

    typedef struct {
        logic [dkms_pkg::COLUMN_W-1:0] cols;
        logic [dkms_pkg::ROW_W-1:0]    rows;
        bit                            typed;     // progress result given below
        logic                          next_col;
        logic [dkms_pkg::LINE_W-1:0]   next_line;
    } sample_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid;
    logic                           in_ready;
    logic [dkms_pkg::COLUMN_W-1:0]  column_levels;
    logic [dkms_pkg::ROW_W-1:0]     row_levels;
    logic                           out_valid;
    logic                           out_ready;
    logic                           drive_is_column;
    logic [dkms_pkg::LINE_W-1:0]    drive_line;
    logic [dkms_pkg::ROW_IDX_W-1:0] row_index;
    logic [dkms_pkg::KEYS_W-1:0]    row_keys;
    logic                           scan_done;
    logic                           changed;
    logic                           last;

    // scan model state
    logic [dkms_pkg::KEYS_W-1:0] key_mat [ROWS];
    int unsigned                 scan_phase;
    logic                        change_seen;

    scan_report_t pending_reports[$];
    sample_row_t  directed_rows[$];
    int           fail_count = 0;
    bit           hold_off_req = 1'b0;
    bit           hold_done = 1'b0;
    bit           quiet = 1'b0;

    duplex_key_matrix_scanner_core #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .column_levels  (column_levels),
        .row_levels     (row_levels),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_is_column(drive_is_column),
        .drive_line     (drive_line),
        .row_index      (row_index),
        .row_keys       (row_keys),
        .scan_done      (scan_done),
        .changed        (changed),
        .last           (last)
    );

    always #5 clk = ~clk;

    task automatic predict_scan_step(input logic [dkms_pkg::COLUMN_W-1:0] cols,
                                     input logic [dkms_pkg::ROW_W-1:0] rows);
        logic [dkms_pkg::KEYS_W-1:0] prev;
        scan_report_t                rep;
        int unsigned                 drv;
        int                          c;
        int                          r;
        if (scan_phase < ROWS)
        begin
            prev = key_mat[scan_phase];
            for (c = 0; c < COLS; c += 2)
                key_mat[scan_phase][c] = ~cols[c];
            if (prev != key_mat[scan_phase])
                change_seen = 1'b1;
        end
        else
        begin
            c = 2 * (scan_phase - ROWS) + 1;
            for (r = 0; r < ROWS; r++)
            begin
                prev = key_mat[r];
                key_mat[r][c] = ~rows[r];
                if (prev != key_mat[r])
                    change_seen = 1'b1;
            end
        end
        scan_phase++;
        if (scan_phase < PHASES)
        begin
            drv = (scan_phase < ROWS) ? scan_phase : 2 * (scan_phase - ROWS) + 1;
            rep.is_col = (scan_phase >= ROWS);
            rep.line   = drv[dkms_pkg::LINE_W-1:0];
            rep.row    = '0;
            rep.keys   = '0;
            rep.done   = 1'b0;
            rep.chg    = 1'b0;
            rep.fin    = 1'b1;
            pending_reports.push_back(rep);
        end
        else
        begin
            // row dump; the next scan starts on row 0
            for (r = 0; r < ROWS; r++)
            begin
                rep.is_col = 1'b0;
                rep.line   = '0;
                rep.row    = r[dkms_pkg::ROW_IDX_W-1:0];
                rep.keys   = key_mat[r];
                rep.done   = 1'b1;
                rep.chg    = change_seen;
                rep.fin    = (r == ROWS - 1);
                pending_reports.push_back(rep);
            end
            scan_phase  = 0;
            change_seen = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        scan_report_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, %s %0d keys %h done %b",
                         $time, "actual row", row_index, row_keys, scan_done);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("drive_is_column", 16'(want.is_col), 16'(drive_is_column));
                check_field("drive_line", 16'(want.line), 16'(drive_line));
                check_field("row_index", 16'(want.row), 16'(row_index));
                check_field("row_keys", 16'(want.keys), 16'(row_keys));
                check_field("scan_done", 16'(want.done), 16'(scan_done));
                check_field("changed", 16'(want.chg), 16'(changed));
                check_field("last", 16'(want.fin), 16'(last));
            end
        end
    end

    // receiver: random stalls, calm stretches, one long hold-off
    initial
    begin
        int calm_left;
        int n;
        calm_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                out_ready = 1'b0;
                for (n = 1; n < LONG_HOLD; n++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else if (quiet || calm_left > 0)
            begin
                out_ready = 1'b1;
                if (calm_left > 0)
                    calm_left--;
            end
            else
            begin
                n = $urandom_range(0, 7);
                if (n == 0)
                begin
                    calm_left = $urandom_range(10, 40);
                    out_ready = 1'b1;
                end
                else if (n < 3)
                begin
                    out_ready = 1'b0;
                    repeat ($urandom_range(1, 6) - 1) @(negedge clk);
                end
                else
                    out_ready = 1'b1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input sample_row_t s);
        in_valid      = 1'b1;
        column_levels = s.cols;
        row_levels    = s.rows;
        do @(posedge clk); while (in_ready !== 1'b1);
        predict_scan_step(s.cols, s.rows);
        if (s.typed)
        begin
            pending_reports[$].is_col = s.next_col;
            pending_reports[$].line   = s.next_line;
        end
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        in_valid      = 1'b0;
        column_levels = dkms_pkg::COLUMN_W'($urandom);
        row_levels    = dkms_pkg::ROW_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    initial
    begin
        logic [dkms_pkg::COLUMN_W-1:0] hist_cols [PHASES];
        logic [dkms_pkg::ROW_W-1:0]    hist_rows [PHASES];
        sample_row_t                   s;
        scan_mode_t                    mode;
        bit                            steady;
        int                            flip_phase;
        int                            bit_idx;
        int unsigned                   p;
        int                            i;

        in_valid      = 1'b0;
        column_levels = '0;
        row_levels    = '0;
        for (i = 0; i < ROWS; i++)
            key_mat[i] = '0;
        for (i = 0; i < PHASES; i++)
        begin
            hist_cols[i] = '0;
            hist_rows[i] = '0;
        end
        scan_phase  = 0;
        change_seen = 1'b0;

        // first scan: every sensed line low, so every key reads pressed
        directed_rows.push_back('{16'h0000, 8'hFF, 1'b1, 1'b0, 4'd1});
        directed_rows.push_back('{16'h0000, 8'h00, 1'b1, 1'b0, 4'd2});
        directed_rows.push_back('{16'h0000, 8'hA5, 1'b1, 1'b0, 4'd3});
        directed_rows.push_back('{16'h0000, 8'h5A, 1'b1, 1'b0, 4'd4});
        directed_rows.push_back('{16'h0000, 8'h01, 1'b1, 1'b0, 4'd5});
        directed_rows.push_back('{16'h0000, 8'h80, 1'b1, 1'b0, 4'd6});
        directed_rows.push_back('{16'h0000, 8'hFE, 1'b1, 1'b0, 4'd7});
        directed_rows.push_back('{16'h0000, 8'h7F, 1'b1, 1'b1, 4'd1});
        directed_rows.push_back('{16'hFFFF, 8'h00, 1'b1, 1'b1, 4'd3});
        directed_rows.push_back('{16'h0000, 8'h00, 1'b1, 1'b1, 4'd5});
        directed_rows.push_back('{16'hAAAA, 8'h00, 1'b1, 1'b1, 4'd7});
        directed_rows.push_back('{16'h5555, 8'h00, 1'b1, 1'b1, 4'd9});
        directed_rows.push_back('{16'hFFFF, 8'h00, 1'b1, 1'b1, 4'd11});
        directed_rows.push_back('{16'h8001, 8'h00, 1'b1, 1'b1, 4'd13});
        directed_rows.push_back('{16'h7FFE, 8'h00, 1'b1, 1'b1, 4'd15});
        directed_rows.push_back('{16'hFFFF, 8'h00, 1'b0, 1'b0, 4'd0});
        // second scan, row phases: released, single columns, mixed
        directed_rows.push_back('{16'hFFFF, 8'h00, 1'b1, 1'b0, 4'd1});
        directed_rows.push_back('{16'h5555, 8'hFF, 1'b1, 1'b0, 4'd2});
        directed_rows.push_back('{16'hAAAA, 8'h00, 1'b1, 1'b0, 4'd3});
        directed_rows.push_back('{16'h0001, 8'hFF, 1'b1, 1'b0, 4'd4});
        directed_rows.push_back('{16'h8000, 8'h00, 1'b1, 1'b0, 4'd5});
        directed_rows.push_back('{16'hFFFE, 8'hFF, 1'b1, 1'b0, 4'd6});
        directed_rows.push_back('{16'h7FFF, 8'h00, 1'b1, 1'b0, 4'd7});
        directed_rows.push_back('{16'h0F0F, 8'hFF, 1'b1, 1'b1, 4'd1});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
        begin
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 6));
            p = scan_phase;
            hist_cols[p] = directed_rows[i].cols;
            hist_rows[p] = directed_rows[i].rows;
            send_word(directed_rows[i]);
        end

        mode       = SCAN_NOISE;
        steady     = 1'b0;
        flip_phase = 0;
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == HOLD_AT)
                hold_off_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                in_valid = 1'b0;
                while (pending_reports.size() != 0)
                    @(negedge clk);
            end
            if (i == QUIET_AT)
                quiet = 1'b1;
            p = scan_phase;
            if (p == 0)
            begin
                mode       = scan_mode_t'($urandom_range(0, 2));
                steady     = ($urandom_range(0, 3) == 0);
                flip_phase = $urandom_range(0, PHASES - 1);
            end
            s.typed     = 1'b0;
            s.next_col  = 1'b0;
            s.next_line = '0;
            s.cols      = dkms_pkg::COLUMN_W'($urandom);
            s.rows      = dkms_pkg::ROW_W'($urandom);
            // repeats keep the sensed lines and scramble the ignored ones
            if (mode != SCAN_NOISE)
            begin
                if (p < ROWS)
                    s.cols = (hist_cols[p] & 16'h5555) | (s.cols & 16'hAAAA);
                else
                    s.rows = hist_rows[p];
                if (mode == SCAN_FLIP && p == flip_phase)
                begin
                    if (p < ROWS)
                    begin
                        bit_idx = 2 * $urandom_range(0, COLS / 2 - 1);
                        s.cols[bit_idx] = ~s.cols[bit_idx];
                    end
                    else
                    begin
                        bit_idx = $urandom_range(0, ROWS - 1);
                        s.rows[bit_idx] = ~s.rows[bit_idx];
                    end
                end
            end
            if (!quiet && !(hold_off_req && !hold_done) && !steady &&
                $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 6));
            hist_cols[p] = s.cols;
            hist_rows[p] = s.rows;
            send_word(s);
        end

        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
